// File: design/utf8_stream_validator_unit_assert.svh
// Assertion macros for the UTF-8 stream validator, included by its top level.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the cycle where ante holds.
`define UTF8V_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8v assertion failed");

// Check that cons holds in the cycle after ante holds.
`define UTF8V_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8v assertion failed");

`else

`define UTF8V_ASSERT_NOW(label, clk, rst, ante, cons)
`define UTF8V_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/utf8v_pkg.sv
// Types and constants shared by the UTF-8 stream validator modules.
package utf8v_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_MAX   = 8'hF4;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;
  localparam logic [7:0] TRAIL_MIN  = 8'h80;
  localparam logic [7:0] TRAIL_MAX  = 8'hBF;
  localparam logic [7:0] TRAIL_A0   = 8'hA0;
  localparam logic [7:0] TRAIL_90   = 8'h90;
  localparam logic [7:0] TRAIL_9F   = 8'h9F;
  localparam logic [7:0] TRAIL_8F   = 8'h8F;

  // Range rule for the first trailer of a sequence.
  typedef enum logic [2:0] {
    RULE_ANY   = 3'd0,
    RULE_A0_BF = 3'd1,
    RULE_80_9F = 3'd2,
    RULE_90_BF = 3'd3,
    RULE_80_8F = 3'd4
  } rule_t;

  // Per-byte classification computed by the front end.
  typedef struct packed {
    logic       ascii;
    logic       lead_ok;
    logic [1:0] lead_len;
    rule_t      lead_rule;
    logic       trl_any;
    logic       trl_a0_bf;
    logic       trl_80_9f;
    logic       trl_90_bf;
    logic       trl_80_8f;
    logic       final_byte;
  } byte_class_t;

  // Back-end state exposed for checking.
  typedef struct packed {
    logic [1:0] trailers_left;
    logic       first_pending;
    logic       error_seen;
  } back_status_t;

endpackage

// File: design/utf8v_front.sv
// Front end: input handshake and per-byte classification.
module utf8v_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   final_byte,
  input  logic                   queue_full,
  output logic                   push,
  output utf8v_pkg::byte_class_t push_entry
);
  import utf8v_pkg::*;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_entry            = '0;
    push_entry.ascii      = !data_byte[7];
    push_entry.lead_ok    = (data_byte >= LEAD_MIN) && (data_byte <= LEAD_MAX);
    push_entry.final_byte = final_byte;

    if (data_byte <= LEAD2_MAX) begin
      push_entry.lead_len = 2'd1;
    end else if (data_byte <= LEAD3_MAX) begin
      push_entry.lead_len = 2'd2;
    end else begin
      push_entry.lead_len = 2'd3;
    end

    case (data_byte)
      LEAD_E0: push_entry.lead_rule = RULE_A0_BF;
      LEAD_ED: push_entry.lead_rule = RULE_80_9F;
      LEAD_F0: push_entry.lead_rule = RULE_90_BF;
      LEAD_F4: push_entry.lead_rule = RULE_80_8F;
      default: push_entry.lead_rule = RULE_ANY;
    endcase

    push_entry.trl_any   = data_byte inside {[TRAIL_MIN:TRAIL_MAX]};
    push_entry.trl_a0_bf = data_byte inside {[TRAIL_A0:TRAIL_MAX]};
    push_entry.trl_80_9f = data_byte inside {[TRAIL_MIN:TRAIL_9F]};
    push_entry.trl_90_bf = data_byte inside {[TRAIL_90:TRAIL_MAX]};
    push_entry.trl_80_8f = data_byte inside {[TRAIL_MIN:TRAIL_8F]};
  end

endmodule

// File: design/utf8v_queue.sv
// Short register queue between the front and back ends.
module utf8v_queue #(
  parameter int Depth = utf8v_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  utf8v_pkg::byte_class_t        push_entry,
  input  logic                          pop,
  output utf8v_pkg::byte_class_t        head,
  output logic                          empty,
  output logic                          full,
  output logic [$clog2(Depth+1)-1:0]    count
);
  import utf8v_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  byte_class_t         entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW-1:0]     wr_ptr_next;
  logic [PtrW-1:0]     rd_ptr_next;
  logic [CntW-1:0]     count_next;

  assign empty = (count == '0);
  assign full  = (count == CntW'(Depth));
  assign head  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
    rd_ptr_next = (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
    count_next  = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

endmodule

// File: design/utf8v_back.sv
// Back end: sequence state update, verdict and output register.
module utf8v_back (
  input  logic                    clk,
  input  logic                    rst,
  input  utf8v_pkg::byte_class_t  head,
  input  logic                    queue_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    is_valid,
  output utf8v_pkg::back_status_t status
);
  import utf8v_pkg::*;

  logic [1:0] trailers_left, trailers_left_next;
  rule_t      rule, rule_next;
  logic       first_pending, first_pending_next;
  logic       error_seen, error_seen_next;
  logic       out_free;
  logic       trl_ok;
  logic       verdict;

  assign out_free = !out_valid || !out_stall;
  // Hold a final byte in the queue until the output slot can take its verdict.
  assign pop      = !queue_empty && (!head.final_byte || out_free);

  always_comb begin
    if (first_pending) begin
      case (rule)
        RULE_A0_BF: trl_ok = head.trl_a0_bf;
        RULE_80_9F: trl_ok = head.trl_80_9f;
        RULE_90_BF: trl_ok = head.trl_90_bf;
        RULE_80_8F: trl_ok = head.trl_80_8f;
        default:    trl_ok = head.trl_any;
      endcase
    end else begin
      trl_ok = head.trl_any;
    end
  end

  always_comb begin
    trailers_left_next = trailers_left;
    rule_next          = rule;
    first_pending_next = first_pending;
    error_seen_next    = error_seen;

    if (trailers_left != 2'd0) begin
      if (trl_ok) begin
        trailers_left_next = trailers_left - 2'd1;
        first_pending_next = 1'b0;
        if (trailers_left == 2'd1) begin
          rule_next = RULE_ANY;
        end
      end else begin
        // Drop the open sequence; the bad byte is not reparsed as a lead.
        error_seen_next    = 1'b1;
        trailers_left_next = 2'd0;
        first_pending_next = 1'b0;
        rule_next          = RULE_ANY;
      end
    end else if (!head.ascii) begin
      if (!head.lead_ok) begin
        error_seen_next = 1'b1;
      end else begin
        trailers_left_next = head.lead_len;
        rule_next          = head.lead_rule;
        first_pending_next = 1'b1;
      end
    end

    verdict = !error_seen_next && (trailers_left_next == 2'd0);

    if (head.final_byte) begin
      trailers_left_next = 2'd0;
      rule_next          = RULE_ANY;
      first_pending_next = 1'b0;
      error_seen_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trailers_left <= 2'd0;
      rule          <= RULE_ANY;
      first_pending <= 1'b0;
      error_seen    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        trailers_left <= trailers_left_next;
        rule          <= rule_next;
        first_pending <= first_pending_next;
        error_seen    <= error_seen_next;
      end
      if (pop && head.final_byte) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.final_byte) begin
      is_valid <= verdict;
    end
  end

  assign status.trailers_left = trailers_left;
  assign status.first_pending = first_pending;
  assign status.error_seen    = error_seen;

endmodule

// File: design/utf8_stream_validator_unit.sv
// Top level of the strict UTF-8 stream validator.
//
// Input channel (in_valid / in_stall): one buffer byte per transaction in
// data_byte, with final_byte set on the last byte of the buffer. An empty
// buffer sends no transaction and gets no verdict.
// Output channel (out_valid / out_stall): one transaction per buffer, sent
// for its final byte; is_valid is 1 when the whole buffer is well-formed.
// Throughput: one byte per cycle, sustained while the queue is not full and no
// final byte waits on a stalled output slot. A final byte is first registered
// in the queue, then popped by the back end, which registers the verdict at
// the output.
// While the receiver stalls, the verdict holds; the back end keeps consuming
// non-final bytes and holds the next final byte in the queue, and in_stall
// rises only once the queue (QueueDepth entries) fills.
// Reset (rst, synchronous) empties the queue, drops any pending verdict and
// clears the sequence state; bytes are taken in the first cycle after it.
module utf8_stream_validator_unit #(
  parameter int QueueDepth = utf8v_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_valid
);
  import utf8v_pkg::*;

  `include "utf8_stream_validator_unit_assert.svh"

  localparam int CntW = $clog2(QueueDepth + 1);

  logic                push;
  byte_class_t         push_entry;
  logic                pop;
  byte_class_t         head;
  logic                queue_empty;
  logic                queue_full;
  logic [CntW-1:0]     queue_count;
  back_status_t        status;

  // Classify each byte as it arrives; stall only when the queue is full.
  utf8v_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple intake from the state update so either side can stall alone.
  utf8v_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty),
    .full       (queue_full),
    .count      (queue_count)
  );

  // Advance the sequence state and register the verdict per buffer.
  utf8v_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_valid    (is_valid),
    .status      (status)
  );

  // Queue occupancy never exceeds its depth.
  `UTF8V_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, queue_count <= CntW'(QueueDepth))
  // A final byte leaves the queue only when the output slot is free.
  `UTF8V_ASSERT_NOW(a_final_slot, clk, rst, pop && head.final_byte,
    !out_valid || !out_stall)
  // After a verdict the sequence state is clear for the next buffer.
  `UTF8V_ASSERT_NEXT(a_clear_after_final, clk, rst, pop && head.final_byte,
    status.trailers_left == 2'd0 && !status.error_seen && !status.first_pending)
  // A first trailer can be pending only inside an open sequence.
  `UTF8V_ASSERT_NOW(a_pending_open, clk, rst, status.first_pending,
    status.trailers_left != 2'd0)

endmodule

// File: test/utf8_stream_validator_unit_tb.sv
// Testbench for the UTF-8 stream validator: directed and random byte buffers checked by a predictor.
`timescale 1ns / 1ps

module utf8_stream_validator_unit_tb;
  import utf8v_pkg::*;

  // Allow for roughly 1350 bytes, long sender gaps and long receiver stalls,
  // with plenty of headroom on top.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BYTES = 1350;
  localparam int REPORT_MAX = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_valid;

  utf8_stream_validator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .final_byte(final_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_valid(is_valid)
  );

  always #10 clk = ~clk;

  // Predicted decoder state, mirrored one byte at a time as the block accepts it.
  logic [1:0] seq_trailers = 2'd0;
  rule_t      seq_rule = RULE_ANY;
  logic       seq_first = 1'b0;
  logic       seq_error = 1'b0;

  logic       verdict_q[$];    // expected is_valid per buffer, oldest first
  logic [7:0] frame_q[$];      // bytes of the buffer being built
  logic       want_verdict;
  int         fault_count = 0;
  int         byte_count = 0;
  int         cycle_count = 0;
  bit         send_quiet = 1'b0;
  bit         stall_quiet = 1'b0;
  int         stall_left = 0;

  // Advance the predicted state by one accepted byte; on the final byte,
  // queue the verdict and clear for the next buffer.
  task automatic track_byte(input logic [7:0] b, input logic fin);
    logic [7:0] lo;
    logic [7:0] hi;
    if (seq_trailers != 2'd0) begin
      lo = TRAIL_MIN;
      hi = TRAIL_MAX;
      if (seq_first) begin
        case (seq_rule)
          RULE_A0_BF: lo = TRAIL_A0;
          RULE_80_9F: hi = TRAIL_9F;
          RULE_90_BF: lo = TRAIL_90;
          RULE_80_8F: hi = TRAIL_8F;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        seq_trailers = seq_trailers - 2'd1;
        seq_first = 1'b0;
        if (seq_trailers == 2'd0) seq_rule = RULE_ANY;
      end else begin
        // A bad trailer drops the open sequence and is not reparsed as a lead.
        seq_error = 1'b1;
        seq_trailers = 2'd0;
        seq_first = 1'b0;
        seq_rule = RULE_ANY;
      end
    end else if (b >= TRAIL_MIN) begin
      if (b < LEAD_MIN || b > LEAD_MAX) begin
        seq_error = 1'b1;
      end else begin
        seq_rule = RULE_ANY;
        seq_first = 1'b1;
        if (b <= LEAD2_MAX) begin
          seq_trailers = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          seq_trailers = 2'd2;
          if (b == LEAD_E0) seq_rule = RULE_A0_BF;
          else if (b == LEAD_ED) seq_rule = RULE_80_9F;
        end else begin
          seq_trailers = 2'd3;
          if (b == LEAD_F0) seq_rule = RULE_90_BF;
          else if (b == LEAD_F4) seq_rule = RULE_80_8F;
        end
      end
    end
    if (fin) begin
      verdict_q.push_back(!seq_error && seq_trailers == 2'd0);
      seq_trailers = 2'd0;
      seq_rule = RULE_ANY;
      seq_first = 1'b0;
      seq_error = 1'b0;
    end
  endtask

  task automatic log_fault(input string what, input logic want, input logic got);
    fault_count++;
    if (fault_count <= REPORT_MAX)
      $display("%0t: %s: expected %b, got %b", $time, what, want, got);
  endtask

  // Mostly short gaps, a few long ones, none at all during a quiet stretch.
  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drop in_valid for a gap given by n; do nothing for n == 0 so that valid stays
  // high between back-to-back transactions.
  task automatic go_idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one byte and hold it until the block takes it. Sample in_stall
  // at the falling edge, where it is settled for the coming rising edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic taken;
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    byte_count++;
    track_byte(b, fin);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      go_idle(pick_send_gap());
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Hold off the sender until every queued verdict has come back.
  task automatic settle_verdicts();
    go_idle(1);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Append one well-formed character of random length and content; bias the
  // leads that narrow the first trailer.
  task automatic add_char();
    int         kind;
    int         n_trail;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        lead = 8'($urandom_range(0, 8'h7F));
        n_trail = 0;
      end
      1: begin
        lead = 8'($urandom_range(LEAD_MIN, LEAD2_MAX));
        n_trail = 1;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: lead = LEAD_E0;
          1: lead = LEAD_ED;
          default: lead = 8'($urandom_range(LEAD_E0, LEAD3_MAX));
        endcase
        n_trail = 2;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: lead = LEAD_F0;
          1: lead = LEAD_F4;
          default: lead = 8'($urandom_range(LEAD_F0, LEAD_MAX));
        endcase
        n_trail = 3;
      end
    endcase
    frame_q.push_back(lead);
    lo = TRAIL_MIN;
    hi = TRAIL_MAX;
    if (lead == LEAD_E0) lo = TRAIL_A0;
    if (lead == LEAD_ED) hi = TRAIL_9F;
    if (lead == LEAD_F0) lo = TRAIL_90;
    if (lead == LEAD_F4) hi = TRAIL_8F;
    for (int i = 0; i < n_trail; i++) begin
      frame_q.push_back(8'($urandom_range(lo, hi)));
      lo = TRAIL_MIN;
      hi = TRAIL_MAX;
    end
  endtask

  task automatic build_wellformed();
    int n_chars;
    n_chars = $urandom_range(1, 6);
    frame_q.delete();
    repeat (n_chars) add_char();
  endtask

  // Boundary bytes, each narrowed first-trailer rule, every error path.
  task automatic test_directed_cases();
    frame_q = '{8'h00};                         send_frame();
    frame_q = '{8'h7F, 8'hFF};                  send_frame();  // top bad lead
    frame_q = '{8'hC1};                         send_frame();  // overlong lead
    frame_q = '{8'hC2, 8'h80};                  send_frame();
    frame_q = '{8'hDF, 8'hBF};                  send_frame();
    frame_q = '{8'hE0, 8'h9F, 8'h80};           send_frame();  // below A0 after E0
    frame_q = '{8'hED, 8'hA0};                  send_frame();  // surrogate range
    frame_q = '{8'hF0, 8'h90, 8'h80, 8'hBF};    send_frame();
    frame_q = '{8'hF4, 8'h90};                  send_frame();  // above U+10FFFF
    frame_q = '{8'hF5};                         send_frame();
    frame_q = '{8'hE1, 8'h80};                  send_frame();  // truncated
    frame_q = '{8'h80, 8'hC2, 8'hBF};           send_frame();  // error stays sticky
  endtask

  // Mostly well-formed buffers with random content; the rest are raw noise,
  // a corrupted byte, or a buffer cut short.
  task automatic test_random_buffers(input int byte_goal);
    int pos;
    while (byte_count < byte_goal) begin
      if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
      build_wellformed();
      case ($urandom_range(0, 9))
        0: begin
          frame_q.delete();
          repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          pos = $urandom_range(0, frame_q.size() - 1);
          frame_q[pos] = 8'($urandom_range(0, 255));
        end
        2: begin
          if (frame_q.size() > 1) void'(frame_q.pop_back());
        end
        default: ;
      endcase
      send_frame();
    end
  endtask

  // Stop sending mid-run until the output side has caught up completely.
  task automatic test_drain_pause();
    repeat (3) begin
      build_wellformed();
      send_frame();
    end
    settle_verdicts();
  endtask

  // Receiver stall: random bursts, most short, a few long, with quiet
  // stretches in which the receiver starts no new stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      if (!out_stall && !stall_quiet && $urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end
      if ($urandom_range(0, 99) == 0) stall_quiet <= !stall_quiet;
    end
  end

  // Check each verdict transaction at the falling edge before the rising edge
  // that takes it; out_stall and out_valid are settled by then.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        log_fault("verdict with none pending", 1'bx, is_valid);
      end else begin
        want_verdict = verdict_q.pop_front();
        if (is_valid !== want_verdict) log_fault("is_valid", want_verdict, is_valid);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("utf8_stream_validator_unit_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_buffers(RANDOM_BYTES / 2);
    test_drain_pause();
    test_random_buffers(RANDOM_BYTES);
    // Drain: wait for the last verdict, then keep the clock running to catch any stray one.
    settle_verdicts();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("utf8_stream_validator_unit_tb passed");
    end else begin
      $display("utf8_stream_validator_unit_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/utf8v_pkg.sv
design/utf8v_front.sv
design/utf8v_queue.sv
design/utf8v_back.sv
design/utf8_stream_validator_unit.sv
test/utf8_stream_validator_unit_tb.sv
